// ===== src/tcpu_pkg.sv =====
// Shared constants, codes and types of the toy CPU execute unit.
package tcpu_pkg;

  localparam int DATA_WORDS = 256;
  localparam int REG_COUNT  = 9;

  localparam logic [15:0] DATA_BASE_RST = 16'd16384;
  localparam logic [31:0] WORD0_RST     = 32'd100;

  localparam logic [0:0] CFG_START_ADDRESS = 1'b0;
  localparam logic [0:0] CFG_DATA_BASE     = 1'b1;

  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_MOVE  = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_AND   = 8'd6;
  localparam logic [7:0] OP_OR    = 8'd7;
  localparam logic [7:0] OP_NOT   = 8'd8;
  localparam logic [7:0] OP_CMP   = 8'd9;
  localparam logic [7:0] OP_JUMP  = 8'd10;
  localparam logic [7:0] OP_IN    = 8'd11;
  localparam logic [7:0] OP_OUT   = 8'd12;
  localparam logic [7:0] OP_LAST  = 8'd15;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OPCODE  = 3'd1;
  localparam logic [2:0] ERR_REG     = 3'd2;
  localparam logic [2:0] ERR_ADDRESS = 3'd3;
  localparam logic [2:0] ERR_DIVZERO = 3'd4;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDS,
    ST_ADDR,
    ST_MRD,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } state_t;

endpackage

// ===== src/toy_cpu_execute_unit_core.sv =====
// Top level of the toy CPU execute unit: sequencer, register file, data memory and divider.
//
// One instruction item is executed at a time. Two register file reads and one data memory read
// go through synchronous RAMs with one read port, one after another, and are followed by
// execute and write-back; write-back holds while the result output is stalled. The next item
// can be accepted while the result is presented. Divide goes through the bit-serial divider
// between execute and write-back. After reset a clearing pass writes the memories to their
// reset contents. No item is accepted during it, but configuration writes are.
module toy_cpu_execute_unit_core #(
  parameter int DATA_WORDS = tcpu_pkg::DATA_WORDS,
  parameter int REG_COUNT  = tcpu_pkg::REG_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  input  logic signed [31:0] in_in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_ip,
  output logic signed [1:0] out_compare_flag,
  output logic [15:0] out_instr_reg,
  output logic        out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic        out_halted,
  output logic [2:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DA = $clog2(DATA_WORDS);
  localparam int RA = $clog2(REG_COUNT);

  tcpu_pkg::state_t state_r, state_nxt;

  logic [DA-1:0] clr_cnt_r;
  logic [15:0]   ip_r;
  logic [1:0]    flag_r;
  logic [15:0]   ir_r;
  logic          halt_r;
  logic [15:0]   base_r;
  logic [31:0]   word_r;
  logic [31:0]   inval_r;
  logic [31:0]   a_r;
  logic [31:0]   rs_r;
  logic [DA-1:0] midx_r;
  logic          aerr_r;
  logic [31:0]   res_r;
  logic          rf_we_r;
  logic          mem_we_r;
  logic [31:0]   mem_wd_r;
  logic          ov_r;
  logic [31:0]   oval_r;
  logic [2:0]    err_r;
  logic          out_valid_r;

  logic          rf_we;
  logic [RA-1:0] rf_waddr;
  logic [31:0]   rf_wdata;
  logic [RA-1:0] rf_raddr;
  logic [31:0]   rf_rdata;
  logic          mem_we;
  logic [DA-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [DA-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  logic [7:0]    op;
  logic [3:0]    fd;
  logic [3:0]    fs;
  logic [31:0]   imm;
  logic          accept;
  logic          clr_last;
  logic          out_free;

  assign op  = word_r[31:24];
  assign fd  = word_r[23:20];
  assign fs  = word_r[19:16];
  assign imm = {{16{word_r[15]}}, word_r[15:0]};

  assign accept   = in_valid && !in_stall;
  assign clr_last = (clr_cnt_r == DA'(DATA_WORDS - 1));
  assign out_free = !out_valid_r || !out_stall;

  // Address computation: (R - base) / 2 truncated toward zero.
  logic [31:0] addr_src;
  logic [33:0] diff;
  logic [33:0] half;
  always_comb begin
    addr_src = (op == tcpu_pkg::OP_MOVE && fs <= 4'd4) ? a_r : rf_rdata;
    diff     = {addr_src[31], addr_src[31], addr_src} - {18'd0, base_r};
    half     = $signed(diff + {33'd0, diff[33]}) >>> 1;
  end

  // Execute stage decode.
  logic        need_d;
  logic        uses_s;
  logic        move_nop;
  logic        store_mv;
  logic [31:0] x;
  logic [2:0]  err;
  logic        commit;
  logic        take_jump;
  logic        a_gt;
  logic [31:0] product;
  always_comb begin
    need_d   = (op >= tcpu_pkg::OP_MOVE && op <= tcpu_pkg::OP_CMP) ||
               op == tcpu_pkg::OP_IN || op == tcpu_pkg::OP_OUT;
    uses_s   = op >= tcpu_pkg::OP_MOVE && op <= tcpu_pkg::OP_CMP && fs != 4'd0;
    move_nop = op == tcpu_pkg::OP_MOVE && fs > 4'd8;
    store_mv = op == tcpu_pkg::OP_MOVE && fs <= 4'd4;
    x        = (uses_s && !move_nop && !store_mv) ? mem_rdata : imm;
    priority if (halt_r) begin
      err = tcpu_pkg::ERR_NONE;
    end else if (op > tcpu_pkg::OP_LAST) begin
      err = tcpu_pkg::ERR_OPCODE;
    end else if (need_d && {1'b0, fd} >= 5'(REG_COUNT)) begin
      err = tcpu_pkg::ERR_REG;
    end else if (uses_s && !move_nop && {1'b0, fs} >= 5'(REG_COUNT)) begin
      err = tcpu_pkg::ERR_REG;
    end else if (uses_s && !move_nop && aerr_r) begin
      err = tcpu_pkg::ERR_ADDRESS;
    end else if (op == tcpu_pkg::OP_DIV && x == 32'd0) begin
      err = tcpu_pkg::ERR_DIVZERO;
    end else begin
      err = tcpu_pkg::ERR_NONE;
    end
    commit    = !halt_r && err == tcpu_pkg::ERR_NONE;
    take_jump = fs == 4'd0 || (fs == 4'd1 && flag_r == tcpu_pkg::FLAG_EQ) ||
                (fs == 4'd2 && flag_r == tcpu_pkg::FLAG_GT) ||
                (fs == 4'd3 && flag_r == tcpu_pkg::FLAG_LT);
    a_gt      = $signed(a_r) > $signed(x);
    product   = a_r * x;
  end

  assign div_start = state_r == tcpu_pkg::ST_EXEC && commit && op == tcpu_pkg::OP_DIV;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcpu_pkg::ST_CLEAR: if (clr_last) state_nxt = tcpu_pkg::ST_IDLE;
      tcpu_pkg::ST_IDLE:  if (accept) state_nxt = tcpu_pkg::ST_RDS;
      tcpu_pkg::ST_RDS:   state_nxt = tcpu_pkg::ST_ADDR;
      tcpu_pkg::ST_ADDR:  state_nxt = tcpu_pkg::ST_MRD;
      tcpu_pkg::ST_MRD:   state_nxt = tcpu_pkg::ST_EXEC;
      tcpu_pkg::ST_EXEC:  state_nxt = div_start ? tcpu_pkg::ST_DIV : tcpu_pkg::ST_WB;
      tcpu_pkg::ST_DIV:   if (div_done) state_nxt = tcpu_pkg::ST_WB;
      tcpu_pkg::ST_WB:    if (out_free) state_nxt = tcpu_pkg::ST_IDLE;
      default:            state_nxt = tcpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != tcpu_pkg::ST_IDLE;
    rf_raddr  = (state_r == tcpu_pkg::ST_IDLE) ? in_instruction_word[20 +: RA] : fs[RA-1:0];
    mem_raddr = midx_r;
    rf_we     = 1'b0;
    rf_waddr  = fd[RA-1:0];
    rf_wdata  = res_r;
    mem_we    = 1'b0;
    mem_waddr = midx_r;
    mem_wdata = mem_wd_r;
    unique case (state_r)
      tcpu_pkg::ST_CLEAR: begin
        rf_we     = {1'b0, clr_cnt_r} < (DA + 1)'(REG_COUNT);
        rf_waddr  = clr_cnt_r[RA-1:0];
        rf_wdata  = 32'd0;
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = (clr_cnt_r == '0) ? tcpu_pkg::WORD0_RST : 32'd0;
      end
      tcpu_pkg::ST_WB: begin
        rf_we  = rf_we_r && out_free;
        mem_we = mem_we_r && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcpu_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      ip_r        <= 16'd0;
      flag_r      <= tcpu_pkg::FLAG_EQ;
      ir_r        <= 16'd0;
      halt_r      <= 1'b0;
      base_r      <= tcpu_pkg::DATA_BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tcpu_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + DA'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tcpu_pkg::CFG_START_ADDRESS: ip_r   <= cfg_wdata;
          tcpu_pkg::CFG_DATA_BASE:     base_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state_r == tcpu_pkg::ST_EXEC && commit) begin
        ir_r <= word_r[31:16];
        ip_r <= (op == tcpu_pkg::OP_JUMP && take_jump) ? ip_r + word_r[15:0] : ip_r + 16'd4;
        if (op == tcpu_pkg::OP_HALT) begin
          halt_r <= 1'b1;
        end
        if (op == tcpu_pkg::OP_CMP) begin
          flag_r <= a_gt ? tcpu_pkg::FLAG_GT :
                    (a_r == x) ? tcpu_pkg::FLAG_EQ : tcpu_pkg::FLAG_LT;
        end
      end
      if (state_r == tcpu_pkg::ST_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r  <= in_instruction_word;
      inval_r <= in_in_value;
    end
    if (state_r == tcpu_pkg::ST_RDS) begin
      a_r <= rf_rdata;
    end
    if (state_r == tcpu_pkg::ST_ADDR) begin
      rs_r   <= rf_rdata;
      midx_r <= half[DA-1:0];
      aerr_r <= half[33] || half >= 34'(DATA_WORDS);
    end
    if (state_r == tcpu_pkg::ST_EXEC) begin
      err_r    <= err;
      ov_r     <= commit && op == tcpu_pkg::OP_OUT;
      oval_r   <= (commit && op == tcpu_pkg::OP_OUT) ? a_r : 32'd0;
      mem_we_r <= commit && ((store_mv && fs != 4'd0) || (op == tcpu_pkg::OP_NOT && fs != 4'd0));
      mem_wd_r <= store_mv ? rs_r : {31'd0, x == 32'd0};
      rf_we_r  <= commit && ((op == tcpu_pkg::OP_MOVE && (fs == 4'd0 || (fs >= 4'd5 && !move_nop)))
                  || (op >= tcpu_pkg::OP_ADD && op <= tcpu_pkg::OP_OR)
                  || (op == tcpu_pkg::OP_NOT && fs == 4'd0) || op == tcpu_pkg::OP_IN);
      unique case (op)
        tcpu_pkg::OP_MOVE: res_r <= (fs == 4'd0) ? imm : x;
        tcpu_pkg::OP_ADD:  res_r <= a_r + x;
        tcpu_pkg::OP_SUB:  res_r <= a_r - x;
        tcpu_pkg::OP_MUL:  res_r <= product;
        tcpu_pkg::OP_AND:  res_r <= {31'd0, a_r != 32'd0 && x != 32'd0};
        tcpu_pkg::OP_OR:   res_r <= {31'd0, a_r != 32'd0 || x != 32'd0};
        tcpu_pkg::OP_NOT:  res_r <= {31'd0, a_r == 32'd0};
        tcpu_pkg::OP_IN:   res_r <= inval_r;
        default:           res_r <= 32'd0;
      endcase
    end
    if (state_r == tcpu_pkg::ST_DIV && div_done) begin
      res_r <= div_q;
    end
    if (state_r == tcpu_pkg::ST_WB && out_free) begin
      out_next_ip      <= ip_r;
      out_compare_flag <= flag_r;
      out_instr_reg    <= ir_r;
      out_out_valid    <= ov_r;
      out_out_value    <= oval_r;
      out_halted       <= halt_r;
      out_error_code   <= err_r;
    end
  end

  assign out_valid = out_valid_r;

  tcpu_ram #(
    .WIDTH(32),
    .DEPTH(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (rf_waddr),
    .wdata  (rf_wdata),
    .raddr  (rf_raddr),
    .rdata_r(rf_rdata)
  );

  tcpu_ram #(
    .WIDTH(32),
    .DEPTH(DATA_WORDS)
  ) u_datamem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (mem_raddr),
    .rdata_r(mem_rdata)
  );

  tcpu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(a_r),
    .divisor (x),
    .done_r  (div_done),
    .quotient(div_q)
  );

endmodule

// ===== src/tcpu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tcpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/tcpu_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module tcpu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done_r,
  output logic [31:0] quotient
);

  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic [32:0] trial;
  logic        fits;

  assign rem_sh   = {rem_r, quo_r[31]};
  assign trial    = rem_sh - {1'b0, dvs_r};
  assign fits     = !trial[32];
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      quo_r <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_r <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      rem_r <= fits ? trial[31:0] : rem_sh[31:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end

endmodule

// ===== tb/tb_toy_cpu_execute_unit_core.sv =====
// Self-checking testbench of the toy CPU execute unit: directed table, random programs.
module tb_toy_cpu_execute_unit_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          SETTLE_CYCLES  = 60;
  localparam int          RANDOM_ITEMS   = 820;
  localparam logic [7:0]  OP_LOCK        = 8'd13;
  localparam logic [7:0]  OP_RELEASE     = 8'd14;
  localparam logic [7:0]  OP_SLEEP       = 8'd15;
  localparam logic [3:0]  SRC_IMM        = 4'd0;
  localparam logic [3:0]  SRC_STORE_LAST = 4'd4;
  localparam logic [3:0]  SRC_LOAD_LAST  = 4'd8;
  localparam logic [3:0]  JMP_ALWAYS     = 4'd0;
  localparam logic [3:0]  JMP_EQ         = 4'd1;
  localparam logic [3:0]  JMP_GT         = 4'd2;
  localparam logic [3:0]  JMP_LT         = 4'd3;

  typedef struct packed {
    logic [15:0] next_ip;
    logic [1:0]  flag;
    logic [15:0] instr_reg;
    logic        emit;
    logic [31:0] value;
    logic        halted;
    logic [2:0]  err;
  } exec_result_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] value;
    logic        has_err;
    logic [2:0]  err;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instruction_word;
  logic signed [31:0] in_in_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_next_ip;
  logic signed [1:0] out_compare_flag;
  logic [15:0] out_instr_reg;
  logic        out_out_valid;
  logic signed [31:0] out_out_value;
  logic        out_halted;
  logic [2:0]  out_error_code;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  logic [31:0] cpu_regs [16];
  logic [31:0] cpu_mem [tcpu_pkg::DATA_WORDS];
  logic [15:0] cpu_ip;
  logic [1:0]  cpu_flag;
  logic [15:0] cpu_ir;
  logic        cpu_halted;
  logic [15:0] cpu_base;

  exec_result_t pending_results [$];
  int          mismatch_cnt;
  int          cycle_cnt;
  int          stall_left;
  bit          quiet_phase;
  stim_row_t   dir_tab [30];

  toy_cpu_execute_unit_core i_dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] mk(logic [7:0] op, logic [3:0] d, logic [3:0] s,
                                     logic [15:0] imm);
    return {op, d, s, imm};
  endfunction

  function automatic bit data_index(logic [31:0] r, output int idx);
    longint diff;
    longint q;
    diff = longint'($signed(r)) - longint'(cpu_base);
    q = diff / 2;
    idx = int'(q);
    return (q >= 0) && (q < tcpu_pkg::DATA_WORDS);
  endfunction

  function automatic exec_result_t execute_instr(logic [31:0] w, logic [31:0] inval);
    logic [7:0]   op;
    logic [3:0]   d;
    logic [3:0]   s;
    logic [31:0]  imm;
    logic [31:0]  x;
    logic [31:0]  a;
    logic [15:0]  nip;
    logic [2:0]   err;
    int           idx;
    bit           need_d;
    exec_result_t res;
    op = w[31:24];
    d = w[23:20];
    s = w[19:16];
    imm = {{16{w[15]}}, w[15:0]};
    x = imm;
    nip = cpu_ip + 16'd4;
    err = tcpu_pkg::ERR_NONE;
    idx = 0;
    res = '0;
    if (cpu_halted) begin
    end else if (op > tcpu_pkg::OP_LAST) begin
      err = tcpu_pkg::ERR_OPCODE;
    end else begin
      need_d = (op >= tcpu_pkg::OP_MOVE && op <= tcpu_pkg::OP_CMP) ||
               op == tcpu_pkg::OP_IN || op == tcpu_pkg::OP_OUT;
      if (need_d && d >= tcpu_pkg::REG_COUNT) err = tcpu_pkg::ERR_REG;
      if (err == tcpu_pkg::ERR_NONE && op >= tcpu_pkg::OP_MOVE && op <= tcpu_pkg::OP_CMP &&
          s != SRC_IMM) begin
        if (op == tcpu_pkg::OP_MOVE && s > SRC_LOAD_LAST) begin
        end else if (s >= tcpu_pkg::REG_COUNT) begin
          err = tcpu_pkg::ERR_REG;
        end else if (op == tcpu_pkg::OP_MOVE && s <= SRC_STORE_LAST) begin
          if (!data_index(cpu_regs[d], idx)) err = tcpu_pkg::ERR_ADDRESS;
        end else begin
          if (!data_index(cpu_regs[s], idx)) err = tcpu_pkg::ERR_ADDRESS;
          else x = cpu_mem[idx];
        end
      end
      if (err == tcpu_pkg::ERR_NONE && op == tcpu_pkg::OP_DIV && x == 32'd0)
        err = tcpu_pkg::ERR_DIVZERO;
      if (err == tcpu_pkg::ERR_NONE) begin
        a = cpu_regs[d];
        case (op)
          tcpu_pkg::OP_HALT: cpu_halted = 1'b1;
          tcpu_pkg::OP_MOVE: begin
            if (s == SRC_IMM) cpu_regs[d] = imm;
            else if (s <= SRC_STORE_LAST) cpu_mem[idx] = cpu_regs[s];
            else if (s <= SRC_LOAD_LAST) cpu_regs[d] = x;
          end
          tcpu_pkg::OP_ADD: cpu_regs[d] = a + x;
          tcpu_pkg::OP_SUB: cpu_regs[d] = a - x;
          tcpu_pkg::OP_MUL: cpu_regs[d] = a * x;
          tcpu_pkg::OP_DIV: begin
            if (a == 32'h8000_0000 && x == 32'hFFFF_FFFF) cpu_regs[d] = a;
            else cpu_regs[d] = $signed(a) / $signed(x);
          end
          tcpu_pkg::OP_AND: cpu_regs[d] = {31'd0, (a != 0) && (x != 0)};
          tcpu_pkg::OP_OR:  cpu_regs[d] = {31'd0, (a != 0) || (x != 0)};
          tcpu_pkg::OP_NOT: begin
            if (s == SRC_IMM) cpu_regs[d] = {31'd0, a == 0};
            else cpu_mem[idx] = {31'd0, x == 0};
          end
          tcpu_pkg::OP_CMP: begin
            if ($signed(a) > $signed(x)) cpu_flag = tcpu_pkg::FLAG_GT;
            else if (a == x) cpu_flag = tcpu_pkg::FLAG_EQ;
            else cpu_flag = tcpu_pkg::FLAG_LT;
          end
          tcpu_pkg::OP_JUMP: begin
            if (s == JMP_ALWAYS || (s == JMP_EQ && cpu_flag == tcpu_pkg::FLAG_EQ) ||
                (s == JMP_GT && cpu_flag == tcpu_pkg::FLAG_GT) ||
                (s == JMP_LT && cpu_flag == tcpu_pkg::FLAG_LT))
              nip = cpu_ip + imm[15:0];
          end
          tcpu_pkg::OP_IN: cpu_regs[d] = inval;
          tcpu_pkg::OP_OUT: begin
            res.emit = 1'b1;
            res.value = a;
          end
          default: ;
        endcase
        cpu_ir = w[31:16];
        cpu_ip = nip;
      end
    end
    res.next_ip = cpu_ip;
    res.flag = cpu_flag;
    res.instr_reg = cpu_ir;
    res.halted = cpu_halted;
    res.err = err;
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [31:0] w, logic [31:0] v, bit has_err, logic [2:0] err);
    int gap;
    exec_result_t res;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= w;
    in_in_value <= v;
    do @(posedge clk); while (in_stall);
    res = execute_instr(w, v);
    if (has_err) res.err = err;
    pending_results.push_back(res);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcpu_pkg::CFG_START_ADDRESS) begin
      cpu_ip = val;
    end else begin
      cpu_base = val;
    end
  endtask

  task automatic random_item();
    logic [7:0]  op;
    logic [3:0]  d;
    logic [3:0]  s;
    logic [31:0] v;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 4) op = 8'($urandom_range(16, 255));
    else if (r < 22) op = tcpu_pkg::OP_IN;
    else op = 8'($urandom_range(1, 15));
    d = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    r = $urandom_range(0, 99);
    if (r < 50) s = SRC_IMM;
    else if (r < 94) s = 4'($urandom_range(1, 8));
    else s = 4'($urandom_range(9, 15));
    if (op == tcpu_pkg::OP_JUMP) s = 4'($urandom_range(0, 5));
    if ($urandom_range(0, 9) < 6)
      v = 32'(cpu_base) + 32'($urandom_range(0, 2 * tcpu_pkg::DATA_WORDS + 3)) - 32'd2;
    else
      v = $urandom;
    send_item({op, d, s, 16'($urandom)}, v, 1'b0, tcpu_pkg::ERR_NONE);
  endtask

  always @(posedge clk) begin
    exec_result_t e;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        mismatch_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_next_ip !== e.next_ip) begin
          $error("next_ip exp %h got %h", e.next_ip, out_next_ip);
          mismatch_cnt++;
        end
        if (out_compare_flag !== e.flag) begin
          $error("compare_flag exp %b got %b", e.flag, out_compare_flag);
          mismatch_cnt++;
        end
        if (out_instr_reg !== e.instr_reg) begin
          $error("instr_reg exp %h got %h", e.instr_reg, out_instr_reg);
          mismatch_cnt++;
        end
        if (out_out_valid !== e.emit) begin
          $error("out_valid exp %b got %b", e.emit, out_out_valid);
          mismatch_cnt++;
        end
        if (out_out_value !== e.value) begin
          $error("out_value exp %h got %h", e.value, out_out_value);
          mismatch_cnt++;
        end
        if (out_halted !== e.halted) begin
          $error("halted exp %b got %b", e.halted, out_halted);
          mismatch_cnt++;
        end
        if (out_error_code !== e.err) begin
          $error("error_code exp %0d got %0d", e.err, out_error_code);
          mismatch_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_instruction_word = '0;
    in_in_value = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tcpu_pkg::CFG_START_ADDRESS;
    cfg_wdata = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    stall_left = 0;
    quiet_phase = 1'b0;
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_mem[0] = tcpu_pkg::WORD0_RST;
    cpu_base = tcpu_pkg::DATA_BASE_RST;
    cpu_ip = '0;
    cpu_flag = tcpu_pkg::FLAG_EQ;
    cpu_ir = '0;
    cpu_halted = 1'b0;

    dir_tab = '{
      '{mk(tcpu_pkg::OP_IN, 4'd0, 4'd0, 16'h0), 32'd16390, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_IN, 4'd5, 4'd0, 16'h0), 32'd16384, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_IN, 4'd3, 4'd0, 16'h0), 32'h8000_0000, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_IN, 4'd4, 4'd0, 16'h0), 32'h7FFF_FFFF, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_MOVE, 4'd2, 4'd5, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_MOVE, 4'd1, SRC_IMM, 16'hFFFB), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_MOVE, 4'd0, 4'd1, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_MOVE, 4'd8, 4'd15, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_ADD, 4'd2, 4'd5, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_SUB, 4'd1, SRC_IMM, 16'h8000), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_MUL, 4'd4, SRC_IMM, 16'h7FFF), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_DIV, 4'd3, SRC_IMM, 16'hFFFF), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_DIV, 4'd1, SRC_IMM, 16'h0), 32'h0, 1'b1, tcpu_pkg::ERR_DIVZERO},
      '{mk(tcpu_pkg::OP_AND, 4'd2, SRC_IMM, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_OR, 4'd2, 4'd5, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_NOT, 4'd1, SRC_IMM, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_NOT, 4'd0, 4'd0, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_CMP, 4'd4, SRC_IMM, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_JUMP, 4'd0, JMP_GT, 16'h0010), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_CMP, 4'd3, SRC_IMM, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_JUMP, 4'd0, JMP_LT, 16'hFFF8), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_JUMP, 4'd0, JMP_EQ, 16'h0100), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_JUMP, 4'd0, JMP_ALWAYS, 16'h8000), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_OUT, 4'd4, 4'd0, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE},
      '{mk(tcpu_pkg::OP_OUT, 4'd9, 4'd0, 16'h0), 32'h0, 1'b1, tcpu_pkg::ERR_REG},
      '{mk(tcpu_pkg::OP_ADD, 4'd0, 4'd9, 16'h0), 32'h0, 1'b1, tcpu_pkg::ERR_REG},
      '{mk(tcpu_pkg::OP_MOVE, 4'd3, 4'd1, 16'h0), 32'h0, 1'b1, tcpu_pkg::ERR_ADDRESS},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, tcpu_pkg::ERR_OPCODE},
      '{mk(8'd16, 4'd0, 4'd0, 16'h0), 32'h0, 1'b1, tcpu_pkg::ERR_OPCODE},
      '{mk(OP_LOCK, 4'd15, 4'd15, 16'hFFFF), 32'h0, 1'b0, tcpu_pkg::ERR_NONE}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].word, dir_tab[i].value,
                                   dir_tab[i].has_err, dir_tab[i].err);
    send_item(mk(OP_RELEASE, 4'd0, 4'd0, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE);
    send_item(mk(OP_SLEEP, 4'd0, 4'd0, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_cfg(tcpu_pkg::CFG_START_ADDRESS, 16'd65532);
          write_cfg(tcpu_pkg::CFG_DATA_BASE, 16'd0);
        end
        2: begin
          write_cfg(tcpu_pkg::CFG_START_ADDRESS, 16'(4 * $urandom_range(0, 16383)));
          write_cfg(tcpu_pkg::CFG_DATA_BASE, 16'd65535);
        end
        3: begin
          write_cfg(tcpu_pkg::CFG_START_ADDRESS, 16'd0);
          write_cfg(tcpu_pkg::CFG_DATA_BASE, 16'($urandom));
        end
        default: ;
      endcase
      quiet_phase = (phase == 2);
      repeat (RANDOM_ITEMS / 4) random_item();
    end

    send_item(mk(tcpu_pkg::OP_HALT, 4'd0, 4'd0, 16'h0), 32'h0, 1'b0, tcpu_pkg::ERR_NONE);
    repeat (4) random_item();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcpu_pkg.sv
src/tcpu_ram.sv
src/tcpu_div.sv
src/toy_cpu_execute_unit_core.sv
tb/tb_toy_cpu_execute_unit_core.sv
